/* src/skfk_pkg.sv */
package skfk_pkg;

    localparam int MAX_JOINTS_DEFAULT = 256;
    localparam int FRAC_BITS_DEFAULT  = 16;
    localparam int IDX_W              = 10;
    localparam int QUAT_FRAC          = 28;

    typedef struct packed {
        logic               first_joint;
        logic        [7:0]  parent_id;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } item_t;

    typedef struct packed {
        logic        [7:0]  joint_number;
        logic        [1:0]  row_number;
        logic signed [31:0] col_0;
        logic signed [31:0] col_1;
        logic signed [31:0] col_2;
        logic signed [31:0] col_3;
        logic               bad_parent;
        logic               last_row;
    } result_t;

    typedef struct packed {
        item_t            item;
        logic [IDX_W-1:0] idx;
        logic             root;
        logic             bad;
        logic             keep_z;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_QMUL,
        B_ROT,
        B_LMUL,
        B_DECIDE,
        B_PLOAD,
        B_GMUL,
        B_EMIT
    } back_state_t;

endpackage

/* src/skeleton_forward_kinematics_core.sv */
// Rows: a root or bad-parent joint skips the parent load and global multiply steps; the
//   three rows of each joint follow one per cycle while the output is not stalled.
// Joints are worked one at a time on the single shared 32x32 multiplier (9 quaternion,
//   12 local and, for a joint with a valid parent, 39 parent slots).
// Reset: async active low; joint counter zero, root motion enabled, matrix store undefined.
module skeleton_forward_kinematics_core #(
    parameter int MAX_JOINTS = skfk_pkg::MAX_JOINTS_DEFAULT,
    parameter int FRAC_BITS  = skfk_pkg::FRAC_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              item_valid,
    output logic              item_stall,
    input  skfk_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output skfk_pkg::result_t result
);

    skfk_pkg::job_t push_data;
    skfk_pkg::job_t pop_data;
    logic           push, full, pop, q_valid;

    skfk_front #(
        .MAX_JOINTS(MAX_JOINTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item      (item),
        .full      (full),
        .push      (push),
        .job       (push_data)
    );

    skfk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .pop      (pop),
        .valid    (q_valid),
        .pop_data (pop_data)
    );

    skfk_back #(
        .MAX_JOINTS(MAX_JOINTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (pop_data),
        .pop         (pop),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

endmodule

/* src/skfk_front.sv */
module skfk_front #(
    parameter int MAX_JOINTS = skfk_pkg::MAX_JOINTS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    input  logic            item_valid,
    output logic            item_stall,
    input  skfk_pkg::item_t item,
    input  logic            full,
    output logic            push,
    output skfk_pkg::job_t  job
);

    localparam int JW = $clog2(MAX_JOINTS);

    logic [JW-1:0] cnt_reg;
    logic [JW-1:0] cnt_next;
    logic [JW-1:0] idx;
    logic          keep_z_reg;

    assign item_stall = full;
    assign push       = item_valid && !full;

    always_comb
    begin
        idx      = item.first_joint ? '0 : cnt_reg;
        cnt_next = (idx == JW'(MAX_JOINTS - 1)) ? '0 : idx + 1'b1;
        job.item   = item;
        job.idx    = skfk_pkg::IDX_W'(idx);
        job.root   = item.first_joint;
        job.bad    = !item.first_joint &&
                     (skfk_pkg::IDX_W'(item.parent_id) >= skfk_pkg::IDX_W'(idx));
        job.keep_z = keep_z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            keep_z_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
                keep_z_reg <= cfg_wdata;
            if (push)
                cnt_reg <= cnt_next;
        end
    end

endmodule

/* src/skfk_queue.sv */
module skfk_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  skfk_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output skfk_pkg::job_t pop_data
);

    skfk_pkg::job_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* src/skfk_back.sv */
module skfk_back #(
    parameter int MAX_JOINTS = skfk_pkg::MAX_JOINTS_DEFAULT,
    parameter int FRAC_BITS  = skfk_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  skfk_pkg::job_t     q_data,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output skfk_pkg::result_t  result
);

    localparam int DEPTH = MAX_JOINTS * 12;
    localparam int AW    = $clog2(DEPTH);
    localparam int RSH   = skfk_pkg::QUAT_FRAC - FRAC_BITS;
    localparam logic [3:0] QMUL_LAST  = 4'd8;
    localparam logic [3:0] ENTRY_LAST = 4'd11;
    localparam logic [3:0] PLOAD_LAST = 4'd12;
    localparam logic [3:0] ROW_LAST   = 4'd2;
    localparam logic signed [35:0] ONE  = 36'sd1 <<< skfk_pkg::QUAT_FRAC;
    localparam logic signed [35:0] HALF = 36'sd1 <<< (RSH - 1);

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
        rnd = (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    skfk_pkg::back_state_t state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic [1:0]  k_reg, k_next;
    logic        phase_reg, phase_next;
    logic        out_valid_reg;

    skfk_pkg::job_t     job_reg;
    skfk_pkg::result_t  out_reg;
    skfk_pkg::result_t  out_val;
    logic signed [31:0] qp_reg   [9];
    logic signed [31:0] r_reg    [12];
    logic signed [31:0] loc_reg  [12];
    logic signed [31:0] p_reg    [12];
    logic signed [31:0] glob_reg [12];
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic               mem_we;

    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic [1:0]         kidx;
    logic signed [35:0] q2 [9];
    logic signed [35:0] rq [12];
    logic signed [31:0] rr [12];
    logic signed [31:0] loc_val;
    logic signed [63:0] g_term, g_sum;
    logic signed [31:0] g_val;
    logic               g_last;
    logic               load_out;

    // shared multiplier operands
    always_comb
    begin
        ma   = '0;
        mb   = '0;
        kidx = (k_reg == 2'd3) ? 2'd0 : k_reg;
        case (state_reg)
            skfk_pkg::B_QMUL:
            begin
                case (step_reg)
                    4'd0:    begin ma = 32'(job_reg.item.quat_x); mb = 32'(job_reg.item.quat_x); end
                    4'd1:    begin ma = 32'(job_reg.item.quat_y); mb = 32'(job_reg.item.quat_y); end
                    4'd2:    begin ma = 32'(job_reg.item.quat_z); mb = 32'(job_reg.item.quat_z); end
                    4'd3:    begin ma = 32'(job_reg.item.quat_x); mb = 32'(job_reg.item.quat_y); end
                    4'd4:    begin ma = 32'(job_reg.item.quat_x); mb = 32'(job_reg.item.quat_z); end
                    4'd5:    begin ma = 32'(job_reg.item.quat_y); mb = 32'(job_reg.item.quat_z); end
                    4'd6:    begin ma = 32'(job_reg.item.quat_w); mb = 32'(job_reg.item.quat_x); end
                    4'd7:    begin ma = 32'(job_reg.item.quat_w); mb = 32'(job_reg.item.quat_y); end
                    default: begin ma = 32'(job_reg.item.quat_w); mb = 32'(job_reg.item.quat_z); end
                endcase
            end
            skfk_pkg::B_LMUL:
            begin
                ma = r_reg[step_reg];
                case (step_reg[1:0])
                    2'd0:    mb = job_reg.item.scale_x;
                    2'd1:    mb = job_reg.item.scale_y;
                    default: mb = job_reg.item.scale_z;
                endcase
            end
            skfk_pkg::B_GMUL:
            begin
                ma = p_reg[{step_reg[3:2], k_reg}];
                mb = (k_reg == 2'd3) ? '0 : loc_reg[{kidx, step_reg[1:0]}];
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        prod = 64'(ma) * 64'(mb);
    end

    // rotation entries, quaternion product order: xx yy zz xy xz yz wx wy wz
    always_comb
    begin
        for (int n = 0; n < 9; n++)
            q2[n] = 36'(qp_reg[n]);
        rq[0]  = ONE - ((q2[1] + q2[2]) <<< 1);
        rq[1]  = (q2[3] - q2[8]) <<< 1;
        rq[2]  = (q2[4] + q2[7]) <<< 1;
        rq[3]  = '0;
        rq[4]  = (q2[3] + q2[8]) <<< 1;
        rq[5]  = ONE - ((q2[0] + q2[2]) <<< 1);
        rq[6]  = (q2[5] - q2[6]) <<< 1;
        rq[7]  = '0;
        rq[8]  = (q2[4] - q2[7]) <<< 1;
        rq[9]  = (q2[5] + q2[6]) <<< 1;
        rq[10] = ONE - ((q2[0] + q2[1]) <<< 1);
        rq[11] = '0;
        for (int n = 0; n < 12; n++)
            rr[n] = 32'((rq[n] + HALF) >>> RSH);
    end

    always_comb
    begin
        if (step_reg[1:0] == 2'd3)
        begin
            case (step_reg[3:2])
                2'd0:    loc_val = job_reg.item.trans_x;
                2'd1:    loc_val = job_reg.item.trans_y;
                default: loc_val = (job_reg.root && !job_reg.keep_z) ? '0
                                                                      : job_reg.item.trans_z;
            endcase
        end
        else
            loc_val = sat32(rnd(prod_reg));
        g_term = (k_reg == 2'd3) ? 64'(ma) : rnd(prod_reg);
        g_sum  = acc_reg + g_term;
        g_val  = sat32(g_sum);
        g_last = (k_reg == 2'd3) || ((k_reg == 2'd2) && (step_reg[1:0] != 2'd3));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        phase_next = phase_reg;
        case (state_reg)
            skfk_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = skfk_pkg::B_QMUL;
                    step_next  = '0;
                    k_next     = '0;
                    phase_next = 1'b0;
                end
            end
            skfk_pkg::B_QMUL:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (step_reg == QMUL_LAST)
                    begin
                        state_next = skfk_pkg::B_ROT;
                        step_next  = '0;
                    end
                    else
                        step_next = step_reg + 1'b1;
                end
            end
            skfk_pkg::B_ROT:
                state_next = skfk_pkg::B_LMUL;
            skfk_pkg::B_LMUL:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (step_reg == ENTRY_LAST)
                    begin
                        state_next = skfk_pkg::B_DECIDE;
                        step_next  = '0;
                    end
                    else
                        step_next = step_reg + 1'b1;
                end
            end
            skfk_pkg::B_DECIDE:
            begin
                step_next = '0;
                if (job_reg.root || job_reg.bad)
                    state_next = skfk_pkg::B_EMIT;
                else
                    state_next = skfk_pkg::B_PLOAD;
            end
            skfk_pkg::B_PLOAD:
            begin
                if (step_reg == PLOAD_LAST)
                begin
                    state_next = skfk_pkg::B_GMUL;
                    step_next  = '0;
                    k_next     = '0;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            skfk_pkg::B_GMUL:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (g_last)
                    begin
                        k_next = '0;
                        if (step_reg == ENTRY_LAST)
                        begin
                            state_next = skfk_pkg::B_EMIT;
                            step_next  = '0;
                        end
                        else
                            step_next = step_reg + 1'b1;
                    end
                    else
                        k_next = k_reg + 1'b1;
                end
            end
            skfk_pkg::B_EMIT:
            begin
                if (load_out)
                begin
                    if (step_reg == ROW_LAST)
                        state_next = skfk_pkg::B_IDLE;
                    else
                        step_next = step_reg + 1'b1;
                end
            end
            default:
                state_next = skfk_pkg::B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop       = (state_reg == skfk_pkg::B_IDLE) && q_valid;
        load_out  = (state_reg == skfk_pkg::B_EMIT) && (!out_valid_reg || !result_stall);
        rd_addr   = AW'(int'(job_reg.item.parent_id) * 12 + int'(step_reg));
        mem_waddr = AW'(int'(job_reg.idx) * 12 + int'(step_reg));
        mem_we    = 1'b0;
        mem_wdata = loc_val;
        case (state_reg)
            skfk_pkg::B_LMUL:
                mem_we = phase_reg;
            skfk_pkg::B_GMUL:
            begin
                mem_we    = phase_reg && g_last;
                mem_wdata = g_val;
            end
            default:
                mem_we = 1'b0;
        endcase
        out_val.joint_number = job_reg.idx[7:0];
        out_val.row_number   = step_reg[1:0];
        out_val.col_0        = glob_reg[{step_reg[1:0], 2'd0}];
        out_val.col_1        = glob_reg[{step_reg[1:0], 2'd1}];
        out_val.col_2        = glob_reg[{step_reg[1:0], 2'd2}];
        out_val.col_3        = glob_reg[{step_reg[1:0], 2'd3}];
        out_val.bad_parent   = job_reg.bad;
        out_val.last_row     = (step_reg == ROW_LAST);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= q_data;
        if (!phase_reg)
            prod_reg <= prod;
        case (state_reg)
            skfk_pkg::B_QMUL:
            begin
                if (phase_reg)
                    qp_reg[step_reg] <= prod_reg[31:0];
            end
            skfk_pkg::B_ROT:
            begin
                for (int n = 0; n < 12; n++)
                    r_reg[n] <= rr[n];
            end
            skfk_pkg::B_LMUL:
            begin
                if (phase_reg)
                    loc_reg[step_reg] <= loc_val;
            end
            skfk_pkg::B_DECIDE:
            begin
                for (int n = 0; n < 12; n++)
                    glob_reg[n] <= loc_reg[n];
                acc_reg <= '0;
            end
            skfk_pkg::B_PLOAD:
            begin
                if (step_reg != 4'd0)
                    p_reg[step_reg - 1'b1] <= rd_data_reg;
            end
            skfk_pkg::B_GMUL:
            begin
                if (phase_reg)
                begin
                    if (g_last)
                    begin
                        glob_reg[step_reg] <= g_val;
                        acc_reg            <= '0;
                    end
                    else
                        acc_reg <= g_sum;
                end
            end
            default:
                acc_reg <= acc_reg;
        endcase
        if (load_out)
            out_reg <= out_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skfk_pkg::B_IDLE;
            step_reg      <= '0;
            k_reg         <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            phase_reg <= phase_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* tb/skfk_checker.sv */
`timescale 1ns / 100ps

module skfk_checker #(
    parameter int MAX_JOINTS = skfk_pkg::MAX_JOINTS_DEFAULT,
    parameter int FRAC_BITS  = skfk_pkg::FRAC_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              item_valid,
    input  logic              item_stall,
    input  skfk_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  skfk_pkg::result_t result,
    output int                mismatches,
    output int                pending,
    output int                rows_seen
);

    logic              keep_root_z;
    int                next_joint;
    logic [31:0]       pose_store [MAX_JOINTS*12];
    skfk_pkg::result_t rows_due [$];

    function automatic longint rnd(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    task automatic pose_joint(input skfk_pkg::item_t it);
        longint qx, qy, qz, qw, unit, r, acc;
        longint sc [3];
        longint rot [9];
        logic [31:0] loc [12];
        logic [31:0] glob [12];
        logic bad;
        int par;
        qx = it.quat_x;
        qy = it.quat_y;
        qz = it.quat_z;
        qw = it.quat_w;
        unit = 64'sd1 <<< 28;
        sc[0] = it.scale_x;
        sc[1] = it.scale_y;
        sc[2] = it.scale_z;
        bad = 1'b0;
        par = it.parent_id;
        if (it.first_joint)
            next_joint = 0;
        rot[0] = unit - 2 * (qy * qy + qz * qz);
        rot[1] = 2 * (qx * qy - qw * qz);
        rot[2] = 2 * (qx * qz + qw * qy);
        rot[3] = 2 * (qx * qy + qw * qz);
        rot[4] = unit - 2 * (qx * qx + qz * qz);
        rot[5] = 2 * (qy * qz - qw * qx);
        rot[6] = 2 * (qx * qz - qw * qy);
        rot[7] = 2 * (qy * qz + qw * qx);
        rot[8] = unit - 2 * (qx * qx + qy * qy);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r = rnd(rot[i*3+j], 28 - FRAC_BITS);
                loc[i*4+j] = clip32(rnd(r * sc[j], FRAC_BITS));
            end
        end
        loc[3]  = it.trans_x;
        loc[7]  = it.trans_y;
        loc[11] = it.trans_z;
        if (it.first_joint)
        begin
            if (!keep_root_z)
                loc[11] = '0;
            glob = loc;
        end
        else if (par >= next_joint)
        begin
            bad = 1'b1;
            glob = loc;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < 3; k++)
                        acc += rnd(longint'($signed(pose_store[par*12+i*4+k]))
                                   * longint'($signed(loc[k*4+j])), FRAC_BITS);
                    if (j == 3)
                        acc += longint'($signed(pose_store[par*12+i*4+3]));
                    glob[i*4+j] = clip32(acc);
                end
            end
        end
        for (int i = 0; i < 12; i++)
            pose_store[next_joint*12+i] = glob[i];
        for (int i = 0; i < 3; i++)
        begin
            skfk_pkg::result_t row;
            row.joint_number = next_joint[7:0];
            row.row_number   = i[1:0];
            row.col_0        = glob[i*4];
            row.col_1        = glob[i*4+1];
            row.col_2        = glob[i*4+2];
            row.col_3        = glob[i*4+3];
            row.bad_parent   = bad;
            row.last_row     = (i == 2);
            rows_due.insert(rows_due.size(), row);
        end
        next_joint = (next_joint + 1) % MAX_JOINTS;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_root_z = 1'b1;
            next_joint  = 0;
            rows_due.delete();
            mismatches <= 0;
            rows_seen  <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
                keep_root_z = cfg_wdata;
            if (item_valid && !item_stall)
                pose_joint(item);
            if (result_valid && !result_stall)
            begin
                rows_seen <= rows_seen + 1;
                if (rows_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected row %p", result);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    skfk_pkg::result_t want;
                    want = rows_due.pop_front();
                    if (want !== result)
                    begin
                        if (mismatches < 10)
                            $display("row mismatch: expected %p actual %p", want, result);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= rows_due.size();
        end
    end

endmodule

/* tb/skeleton_forward_kinematics_core_test.sv */
`timescale 1ns / 100ps

module skeleton_forward_kinematics_core_test;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_wdata;
    logic              item_valid;
    logic              item_stall;
    skfk_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    skfk_pkg::result_t result;
    int                mismatches;
    int                pending;
    int                rows_seen;
    int                quiet;
    int                joints_sent;
    int                in_chain;
    bit                calm;

    skeleton_forward_kinematics_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    skfk_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .mismatches(mismatches), .pending(pending), .rows_seen(rows_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (calm)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < 22);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 20000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] pick32();
        case ($urandom_range(7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h00010000;
            3: return 32'hffff0000;
            4: return $urandom;
            default: return $signed($urandom_range(8 << 16)) - (4 << 16);
        endcase
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom);
            default: return $signed(16'($urandom_range(23170))) - 16'sd11585;
        endcase
    endfunction

    task automatic send(input skfk_pkg::item_t it);
        if (!calm)
        begin
            while ($urandom_range(99) < 22)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        joints_sent++;
    endtask

    task automatic joint(input bit root, input int par, input bit full);
        skfk_pkg::item_t it;
        it.first_joint = root;
        it.parent_id = 8'(par);
        it.trans_x = full ? $urandom : pick32();
        it.trans_y = full ? $urandom : pick32();
        it.trans_z = full ? $urandom : pick32();
        it.quat_x = full ? 16'($urandom) : pick16();
        it.quat_y = full ? 16'($urandom) : pick16();
        it.quat_z = full ? 16'($urandom) : pick16();
        it.quat_w = full ? 16'($urandom) : pick16();
        it.scale_x = full ? $urandom : pick32();
        it.scale_y = full ? $urandom : pick32();
        it.scale_z = full ? $urandom : pick32();
        send(it);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_root_z(input bit keep);
        cfg_we <= 1'b1;
        cfg_wdata <= keep;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        skfk_pkg::item_t it;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        item_valid = 0;
        item = '0;
        calm = 0;
        joints_sent = 0;
        in_chain = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        joint(1'b0, 0, 1'b0);
        joint(1'b0, 0, 1'b0);
        joint(1'b0, 5, 1'b1);
        it = '0;
        it.first_joint = 1'b1;
        it.quat_w = 16'sd16384;
        it.scale_x = 32'h00010000; it.scale_y = 32'h00010000; it.scale_z = 32'h00010000;
        it.trans_z = 32'h00030000;
        send(it);
        it.first_joint = 1'b0;
        it.parent_id = '0;
        it.quat_x = 16'h7fff; it.quat_y = 16'h8000; it.quat_z = 16'h7fff;
        it.quat_w = 16'h8000;
        it.scale_x = 32'h7fffffff; it.scale_y = 32'h80000000;
        it.trans_x = 32'h7fffffff; it.trans_y = 32'h80000000;
        send(it);
        it.parent_id = 8'd1;
        it.quat_x = '0; it.quat_y = '0; it.quat_z = '0; it.quat_w = '0;
        it.scale_x = 32'h80000000; it.scale_y = 32'h7fffffff; it.scale_z = 32'hffffffff;
        send(it);
        joint(1'b0, 3, 1'b0);
        joint(1'b0, 255, 1'b0);
        drain();
        set_root_z(1'b0);
        joint(1'b1, 7, 1'b0);
        joint(1'b0, 0, 1'b0);
        joint(1'b0, 1, 1'b1);
        joint(1'b0, 2, 1'b0);
        for (int n = 0; n < 260; n++)
            joint(1'b0, n % 256, 1'b0);
        drain();
        set_root_z(1'b1);
        while (joints_sent < 430)
        begin
            if (joints_sent > 300)
            begin
                calm = (joints_sent < 360);
                if (joints_sent == 361)
                begin
                    drain();
                    set_root_z(1'b0);
                end
            end
            if (in_chain == 0 || $urandom_range(99) < 8)
            begin
                joint(1'b1, $urandom_range(255), $urandom_range(9) == 0);
                in_chain = 1;
            end
            else
            begin
                joint(1'b0, ($urandom_range(9) == 0) ? $urandom_range(255)
                                                     : $urandom_range(in_chain - 1),
                      $urandom_range(9) == 0);
                in_chain = (in_chain + 1) % 256;
            end
        end
        calm = 0;
        drain();
        $display("covered %0d joints and %0d rows: roots, chains, bad parents,", joints_sent,
                 rows_seen);
        $display("counter wrap, saturation and both root-z settings");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
src/skfk_pkg.sv
src/skfk_front.sv
src/skfk_queue.sv
src/skfk_back.sv
src/skeleton_forward_kinematics_core.sv
tb/skfk_checker.sv
tb/skeleton_forward_kinematics_core_test.sv
